// ===== rtl/dhwu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhwu_pkg
// Shared types and constants for the digitizer hit word unpacker.
// ----------------------------------------------------------------------------
package dhwu_pkg;

  typedef enum logic [3:0] {
    KIND_MODULE   = 4'd0,
    KIND_IDENTITY = 4'd1,
    KIND_TIME     = 4'd2,
    KIND_ENERGY   = 4'd3,
    KIND_SUM      = 4'd4,
    KIND_QDC      = 4'd5,
    KIND_EXT      = 4'd6,
    KIND_TRACE    = 4'd7,
    KIND_ERROR    = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    RATE_NONE,
    RATE_100,
    RATE_250,
    RATE_500
  } rate_e;

  localparam int MidDepth = 2;
  localparam int OutDepth = 2;

  typedef struct packed {
    kind_e              kind;
    logic [63:0]        wide;
    logic signed [20:0] corr;
    logic [15:0]        mid;
    logic [15:0]        second;
    logic [7:0]         small_a;
    logic [7:0]         small_b;
    logic [3:0]         small_c;
    logic               flag_a;
    logic               flag_b;
    logic               last;
  } rec_t;

  typedef struct packed {
    rec_t  rec;
    rate_e rate;
  } item_t;

endpackage

// ===== rtl/dhwu_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhwu_fifo
// Small register queue with same-cycle push and pop. DEPTH of 2 or more.
// ----------------------------------------------------------------------------
module dhwu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d;
  logic [AW-1:0]    rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + AW'(1);
    end
    return r;
  endfunction

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wptr_d = do_push ? ptr_inc(wptr_q) : wptr_q;
    rptr_d = do_pop ? ptr_inc(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/dhwu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhwu_front
// Word sequencer: tracks the position within a hit and extracts fields.
// ----------------------------------------------------------------------------
module dhwu_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic            full_i,
  input  logic [31:0]     word_i,
  output logic            item_vld_o,
  output dhwu_pkg::item_t item_o
);

  typedef enum logic [3:0] {
    P_BODY   = 4'd0,
    P_MODULE = 4'd1,
    P_IDENT  = 4'd2,
    P_TLOW   = 4'd3,
    P_THIGH  = 4'd4,
    P_ENERGY = 4'd5,
    P_SUMS   = 4'd6,
    P_QDC    = 4'd7,
    P_EXTLO  = 4'd8,
    P_EXTHI  = 4'd9,
    P_TRACE  = 4'd10
  } phase_e;

  localparam logic [3:0]  SumsLen = 4'd4;
  localparam logic [3:0]  QdcLen  = 4'd8;
  localparam logic [7:0]  Adc16   = 8'd16;

  phase_e        phase_q, phase_d;
  logic [15:0]   rate_q, rate_d;
  logic [7:0]    bits_q, bits_d;
  logic [4:0]    hdr_q, hdr_d;
  logic [12:0]   total_q, total_d;
  logic [31:0]   low_q, low_d;
  logic [3:0]    sc_q, sc_d;
  logic [14:0]   pairs_q, pairs_d;

  logic          take;
  dhwu_pkg::rate_e rsel;
  logic [15:0]   tlen;
  logic [14:0]   pairs_new;
  logic [14:0]   pairs_dec;
  logic [3:0]    sc_inc;
  phase_e        np;

  function automatic dhwu_pkg::rate_e rate_sel(input logic [15:0] r);
    dhwu_pkg::rate_e s;
    case (r)
      16'd100: s = dhwu_pkg::RATE_100;
      16'd250: s = dhwu_pkg::RATE_250;
      16'd500: s = dhwu_pkg::RATE_500;
      default: s = dhwu_pkg::RATE_NONE;
    endcase
    return s;
  endfunction

  function automatic phase_e next_phase(input phase_e from, input logic [4:0] hw,
                                        input logic [14:0] pairs);
    phase_e p;
    if (from < P_SUMS && (hw inside {5'd8, 5'd10, 5'd16, 5'd18})) begin
      p = P_SUMS;
    end else if (from < P_QDC && (hw inside {5'd12, 5'd14, 5'd16, 5'd18})) begin
      p = P_QDC;
    end else if (from < P_EXTLO && (hw inside {5'd6, 5'd10, 5'd14, 5'd18})) begin
      p = P_EXTLO;
    end else if (from < P_TRACE && pairs != '0) begin
      p = P_TRACE;
    end else begin
      p = P_BODY;
    end
    return p;
  endfunction

  assign take = push_i & ~full_i;
  assign rsel = rate_sel(rate_q);

  always_comb begin
    phase_d    = phase_q;
    rate_d     = rate_q;
    bits_d     = bits_q;
    hdr_d      = hdr_q;
    total_d    = total_q;
    low_d      = low_q;
    sc_d       = sc_q;
    pairs_d    = pairs_q;
    item_o     = '0;
    item_o.rate = rsel;
    item_vld_o = 1'b0;
    tlen       = '0;
    pairs_new  = '0;
    pairs_dec  = '0;
    sc_inc     = sc_q + 4'd1;
    np         = P_BODY;

    if (take) begin
      case (phase_q)
        P_MODULE: begin
          rate_d                = word_i[15:0];
          bits_d                = word_i[23:16];
          item_vld_o            = 1'b1;
          item_o.rec.kind       = dhwu_pkg::KIND_MODULE;
          item_o.rec.mid        = word_i[15:0];
          item_o.rec.small_a    = word_i[23:16];
          item_o.rec.small_b    = word_i[31:24];
          phase_d               = P_IDENT;
        end
        P_IDENT: begin
          hdr_d                 = word_i[16:12];
          total_d               = word_i[29:17];
          item_vld_o            = 1'b1;
          item_o.rec.kind       = dhwu_pkg::KIND_IDENTITY;
          item_o.rec.small_a    = {4'b0, word_i[3:0]};
          item_o.rec.small_b    = {4'b0, word_i[7:4]};
          item_o.rec.small_c    = word_i[11:8];
          item_o.rec.mid        = {11'b0, word_i[16:12]};
          item_o.rec.wide       = {51'b0, word_i[29:17]};
          item_o.rec.flag_a     = word_i[30];
          item_o.rec.flag_b     = word_i[31];
          phase_d               = P_TLOW;
        end
        P_TLOW: begin
          low_d   = word_i;
          phase_d = P_THIGH;
        end
        P_THIGH: begin
          item_vld_o      = 1'b1;
          item_o.rec.kind = dhwu_pkg::KIND_TIME;
          item_o.rec.wide = {16'b0, word_i[15:0], low_q};
          case (rsel)
            dhwu_pkg::RATE_100: begin
              item_o.rec.flag_a  = word_i[31];
              item_o.rec.mid     = {1'b0, word_i[30:16]};
            end
            dhwu_pkg::RATE_250: begin
              item_o.rec.flag_a  = word_i[31];
              item_o.rec.small_a = {7'b0, word_i[30]};
              item_o.rec.mid     = {2'b0, word_i[29:16]};
            end
            dhwu_pkg::RATE_500: begin
              item_o.rec.small_a = {5'b0, word_i[31:29]};
              item_o.rec.mid     = {3'b0, word_i[28:16]};
            end
            default: begin
            end
          endcase
          phase_d = P_ENERGY;
        end
        P_ENERGY: begin
          item_vld_o = 1'b1;
          if (bits_q == Adc16 && rsel == dhwu_pkg::RATE_250) begin
            tlen              = {1'b0, word_i[30:16]};
            item_o.rec.flag_a = word_i[31];
            item_o.rec.mid    = word_i[15:0];
          end else begin
            tlen              = word_i[31:16];
            item_o.rec.flag_a = word_i[15];
            item_o.rec.mid    = {1'b0, word_i[14:0]};
          end
          pairs_new = tlen[15:1];
          pairs_d   = pairs_new;
          sc_d      = '0;
          if ({3'b0, total_q} != {11'b0, hdr_q} + {1'b0, pairs_new}) begin
            item_o.rec        = '0;
            item_o.rec.kind   = dhwu_pkg::KIND_ERROR;
            item_o.rec.last   = 1'b1;
            phase_d           = P_BODY;
          end else begin
            np                = next_phase(P_ENERGY, hdr_q, pairs_new);
            item_o.rec.kind   = dhwu_pkg::KIND_ENERGY;
            item_o.rec.wide   = {48'b0, tlen};
            item_o.rec.last   = (np == P_BODY);
            phase_d           = np;
          end
        end
        P_SUMS, P_QDC: begin
          item_vld_o         = 1'b1;
          item_o.rec.kind    = (phase_q == P_SUMS) ? dhwu_pkg::KIND_SUM : dhwu_pkg::KIND_QDC;
          item_o.rec.wide    = {32'b0, word_i};
          item_o.rec.small_a = {4'b0, sc_q};
          sc_d               = sc_inc;
          if (sc_inc >= ((phase_q == P_SUMS) ? SumsLen : QdcLen)) begin
            np              = next_phase(phase_q, hdr_q, pairs_q);
            phase_d         = np;
            sc_d            = '0;
            item_o.rec.last = (np == P_BODY);
          end
        end
        P_EXTLO: begin
          low_d   = word_i;
          phase_d = P_EXTHI;
        end
        P_EXTHI: begin
          np              = next_phase(P_EXTHI, hdr_q, pairs_q);
          item_vld_o      = 1'b1;
          item_o.rec.kind = dhwu_pkg::KIND_EXT;
          item_o.rec.wide = {word_i, low_q};
          item_o.rec.last = (np == P_BODY);
          phase_d         = np;
          sc_d            = '0;
        end
        P_TRACE: begin
          item_vld_o        = 1'b1;
          item_o.rec.kind   = dhwu_pkg::KIND_TRACE;
          item_o.rec.mid    = word_i[15:0];
          item_o.rec.second = word_i[31:16];
          pairs_dec         = (pairs_q != '0) ? pairs_q - 15'd1 : pairs_q;
          pairs_d           = pairs_dec;
          if (pairs_dec == '0) begin
            item_o.rec.last = 1'b1;
            phase_d         = P_BODY;
            sc_d            = '0;
          end
        end
        default: begin
          phase_d = P_MODULE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_BODY;
      rate_q  <= '0;
      bits_q  <= '0;
      hdr_q   <= '0;
      total_q <= '0;
      low_q   <= '0;
      sc_q    <= '0;
      pairs_q <= '0;
    end else begin
      phase_q <= phase_d;
      rate_q  <= rate_d;
      bits_q  <= bits_d;
      hdr_q   <= hdr_d;
      total_q <= total_d;
      low_q   <= low_d;
      sc_q    <= sc_d;
      pairs_q <= pairs_d;
    end
  end

endmodule

// ===== rtl/dhwu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhwu_back
// Record formatter: scales the coarse time and builds the CFD correction.
// ----------------------------------------------------------------------------
module dhwu_back (
  input  logic            in_vld_i,
  input  dhwu_pkg::item_t in_item_i,
  input  logic            out_full_i,
  output logic            in_pop_o,
  output logic            out_push_o,
  output dhwu_pkg::rec_t  out_rec_o
);

  logic [47:0] stamp;
  logic [15:0] raw;
  logic [2:0]  trig;
  logic [20:0] corr;

  assign stamp      = in_item_i.rec.wide[47:0];
  assign raw        = in_item_i.rec.mid;
  assign trig       = in_item_i.rec.small_a[2:0];
  assign in_pop_o   = in_vld_i & ~out_full_i;
  assign out_push_o = in_pop_o;

  always_comb begin
    out_rec_o = in_item_i.rec;
    corr      = '0;
    if (in_item_i.rec.kind == dhwu_pkg::KIND_TIME) begin
      case (in_item_i.rate)
        dhwu_pkg::RATE_100: begin
          out_rec_o.wide = 64'({stamp, 3'b0}) + 64'({stamp, 1'b0});
          corr           = 21'({raw, 4'b0}) + 21'({raw, 2'b0});
        end
        dhwu_pkg::RATE_250: begin
          out_rec_o.wide = 64'({stamp, 3'b0});
          corr           = 21'({raw, 4'b0}) - {2'b0, trig[0], 18'b0};
        end
        dhwu_pkg::RATE_500: begin
          out_rec_o.wide = 64'({stamp, 3'b0}) + 64'({stamp, 1'b0});
          corr           = 21'({raw, 4'b0}) + {1'b0, trig, 17'b0} - 21'h20000;
        end
        default: begin
        end
      endcase
    end
    out_rec_o.corr = corr;
  end

endmodule

// ===== rtl/digitizer_hit_word_unpacker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digitizer_hit_word_unpacker_top
// Unpacks a digitizer hit word stream into tagged records.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle, sustained with pop held high.
// A record is registered in the mid queue, then the output queue, on its way to
// the result ports (front sequencer -> mid queue -> formatter -> output queue).
// Words with no record (body size, time low, ext stamp low) only advance state.
// Reset: both queues empty, sequencer expects a body-size word, state zeroed.
module digitizer_hit_word_unpacker_top #(
  parameter int MID_DEPTH = dhwu_pkg::MidDepth,
  parameter int OUT_DEPTH = dhwu_pkg::OutDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [31:0]        word_i,
  output logic               empty,
  input  logic               pop,
  output logic [3:0]         kind_o,
  output logic [63:0]        wide_value_o,
  output logic signed [20:0] correction_fixed_o,
  output logic [15:0]        mid_value_o,
  output logic [15:0]        second_sample_o,
  output logic [7:0]         small_a_o,
  output logic [7:0]         small_b_o,
  output logic [3:0]         small_c_o,
  output logic               flag_a_o,
  output logic               flag_b_o,
  output logic               last_of_hit_o
);

  localparam int ItemW = $bits(dhwu_pkg::item_t);
  localparam int RecW  = $bits(dhwu_pkg::rec_t);

  logic            fr_vld;
  dhwu_pkg::item_t fr_item;
  logic            mid_full, mid_empty, mid_pop;
  logic [ItemW-1:0] mid_data;
  dhwu_pkg::item_t mid_item;
  logic            bk_push;
  dhwu_pkg::rec_t  bk_rec;
  logic            out_full;
  logic [RecW-1:0] out_data;
  dhwu_pkg::rec_t  out_rec;

  assign full     = mid_full;
  assign mid_item = dhwu_pkg::item_t'(mid_data);
  assign out_rec  = dhwu_pkg::rec_t'(out_data);

  dhwu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_i     (mid_full),
    .word_i     (word_i),
    .item_vld_o (fr_vld),
    .item_o     (fr_item)
  );

  dhwu_fifo #(
    .WIDTH (ItemW),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_vld),
    .data_i  (ItemW'(fr_item)),
    .pop_i   (mid_pop),
    .data_o  (mid_data),
    .full_o  (mid_full),
    .empty_o (mid_empty)
  );

  dhwu_back u_back (
    .in_vld_i   (~mid_empty),
    .in_item_i  (mid_item),
    .out_full_i (out_full),
    .in_pop_o   (mid_pop),
    .out_push_o (bk_push),
    .out_rec_o  (bk_rec)
  );

  dhwu_fifo #(
    .WIDTH (RecW),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bk_push),
    .data_i  (RecW'(bk_rec)),
    .pop_i   (pop),
    .data_o  (out_data),
    .full_o  (out_full),
    .empty_o (empty)
  );

  assign kind_o             = out_rec.kind;
  assign wide_value_o       = out_rec.wide;
  assign correction_fixed_o = out_rec.corr;
  assign mid_value_o        = out_rec.mid;
  assign second_sample_o    = out_rec.second;
  assign small_a_o          = out_rec.small_a;
  assign small_b_o          = out_rec.small_b;
  assign small_c_o          = out_rec.small_c;
  assign flag_a_o           = out_rec.flag_a;
  assign flag_b_o           = out_rec.flag_b;
  assign last_of_hit_o      = out_rec.last;

endmodule

// ===== rtl/dhwu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhwu_checker
// Port-level checks on the unpacker result stream.
// ----------------------------------------------------------------------------
module dhwu_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic [3:0]         kind_o,
  input logic [63:0]        wide_value_o,
  input logic signed [20:0] correction_fixed_o,
  input logic [7:0]         small_a_o,
  input logic               last_of_hit_o
);

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == dhwu_pkg::KIND_ERROR) |-> last_of_hit_o)
    else $error("error record without end of hit");

  a_head_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (kind_o == dhwu_pkg::KIND_MODULE || kind_o == dhwu_pkg::KIND_IDENTITY ||
                kind_o == dhwu_pkg::KIND_TIME)) |-> !last_of_hit_o)
    else $error("hit ended on a header record");

  a_corr_time_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != dhwu_pkg::KIND_TIME) |-> correction_fixed_o == '0)
    else $error("correction outside time record");

  a_trace_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == dhwu_pkg::KIND_TRACE) |-> (small_a_o == '0 && wide_value_o == '0))
    else $error("stray fields in trace record");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(kind_o) && $stable(wide_value_o)))
    else $error("stalled record changed");

endmodule

bind digitizer_hit_word_unpacker_top dhwu_checker u_checker (.*);
